// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define ASSERT_IMP_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, a, c)
`define ASSERT_IMP_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/cif_pkg.sv =====
`timescale 1ns / 1ps
package cif_pkg;
	localparam int MaxWidth = 1024;
	localparam int AddrW = $clog2(MaxWidth);
	localparam int NumW = 22;
	localparam int DenW = 14;
	localparam int QuoW = NumW;
	localparam logic [19:0] RecipTen = 20'd838861;

	localparam logic [2:0] REG_WEIGHTS_LOW = 3'd0;
	localparam logic [2:0] REG_WEIGHTS_HIGH = 3'd1;
	localparam logic [2:0] REG_DIVIDER = 3'd2;
	localparam logic [2:0] REG_DIV_MODE = 3'd3;
	localparam logic [2:0] REG_FORMAT = 3'd4;
	localparam logic [2:0] REG_WIDTH = 3'd5;
	localparam logic [2:0] REG_HEIGHT = 3'd6;

	localparam logic [1:0] FMT_GREY = 2'd0;
	localparam logic [1:0] FMT_RGBA = 2'd2;

	typedef struct packed {
		logic start;
		logic [NumW-1:0] num;
		logic [DenW-1:0] den;
	} div_req_t;

	function automatic logic signed [10:0] tap_weight(input logic [98:0] w,
		input logic [3:0] k);
		return w[11*k +: 11];
	endfunction
endpackage

// ===== rtl/cif_divider.sv =====
`timescale 1ns / 1ps
module cif_divider (
	input logic clk,
	input logic arst_n,
	input cif_pkg::div_req_t req,
	output logic done,
	output logic [cif_pkg::QuoW-1:0] quo
);
	import cif_pkg::*;

	logic busy_q;
	logic done_q;
	logic [4:0] cnt_q;
	logic [DenW-1:0] den_q;
	logic [DenW-1:0] rem_q;
	logic [QuoW-1:0] quo_q;
	logic [DenW:0] trial;
	logic ge;

	assign trial = {rem_q, quo_q[QuoW-1]};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= ge ? DenW'(trial - {1'b0, den_q}) : DenW'(trial);
			quo_q <= {quo_q[QuoW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo = quo_q;
endmodule

// ===== rtl/conv3x3_image_filter_top.sv =====
`timescale 1ns / 1ps
// A 3x3 convolution filter over a raster-order pixel stream, with two line
// stores in synchronous RAM. One pixel is taken at a time: a pixel that
// produces no output goes through ST_LOAD and back to ST_IDLE; one that
// completes a window runs each filtered channel (one or three) through the
// taps and the divider, then sends its output beats (up to nine at image
// borders). The per-channel time is set by the nine taps run through one
// shared multiplier and by the 22-step radix-2 divider that scales the sum.
`include "assert_macros.svh"
module conv3x3_image_filter_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [54:0] cfg_wdata,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] chan0_in,
	input logic [7:0] chan1_in,
	input logic [7:0] chan2_in,
	input logic [7:0] alpha_in,
	output logic out_valid,
	input logic out_stall,
	output logic [9:0] out_col,
	output logic [15:0] out_row,
	output logic [7:0] chan0_out,
	output logic [7:0] chan1_out,
	output logic [7:0] chan2_out,
	output logic [7:0] alpha_out,
	output logic run_end,
	output logic frame_end
);
	import cif_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_MUL, ST_ACC, ST_DIV_START, ST_DIV_WAIT, ST_EMIT
	} state_t;

	state_t state_q;
	logic [54:0] wlo_q;
	logic [43:0] whi_q;
	logic signed [10:0] divider_q;
	logic mode_q;
	logic [1:0] fmt_q;
	logic [10:0] width_q;
	logic [15:0] height_q;

	logic [31:0] older_mem [MaxWidth];
	logic [31:0] newer_mem [MaxWidth];
	logic [31:0] top_s1, mid_s1;

	logic [AddrW-1:0] col_q;
	logic [15:0] row_q;
	logic [31:0] wreg_q [6];
	logic [31:0] px_q;
	logic [31:0] win_q [9];
	logic [1:0] ch_q;
	logic [1:0] nch_q;
	logic [3:0] tap_q;
	logic signed [18:0] prod_q;
	logic signed [18:0] acc_q;
	logic signed [14:0] div_q;
	logic [7:0] res_q [3];
	logic [7:0] alpha_q;
	logic [15:0] rows_q [3];
	logic [9:0] cols_q [3];
	logic [1:0] nr_q, nc_q, i_q, j_q;
	logic fend_q;

	logic out_valid_q;
	logic [9:0] out_col_q;
	logic [15:0] out_row_q;
	logic [7:0] c0_q, c1_q, c2_q, a_q;
	logic run_end_q, frame_end_q;

	logic accept;
	logic [10:0] w_eff;
	logic [15:0] h_eff;
	logic emit;
	logic signed [14:0] wsum;
	logic signed [14:0] div_sel;
	logic [98:0] wall;
	logic [17:0] pmag;
	logic [37:0] q10_full;
	logic signed [18:0] q10;
	logic signed [22:0] num10;
	logic div_done;
	logic [QuoW-1:0] quo;
	div_req_t dreq;
	logic out_free;
	logic last_beat;
	logic [7:0] clamped;

	assign accept = in_valid && state_q == ST_IDLE;
	assign in_stall = state_q != ST_IDLE;
	assign wall = {whi_q, wlo_q};

	always_comb begin
		w_eff = width_q;
		if (width_q < 11'd3) w_eff = 11'd3;
		if (width_q > 11'(MaxWidth)) w_eff = 11'(MaxWidth);
		h_eff = (height_q < 16'd3) ? 16'd3 : height_q;
	end

	assign emit = row_q >= 16'd2 && row_q < h_eff && col_q >= AddrW'(2) &&
		{1'b0, col_q} < w_eff;

	always_comb begin
		wsum = '0;
		for (int k = 0; k < 9; k++) begin
			wsum = wsum + 15'(tap_weight(wall, 4'(k)));
		end
		div_sel = mode_q ? wsum : 15'(divider_q);
		if (div_sel == '0) div_sel = 15'sd10;
	end

	assign pmag = prod_q[18] ? 18'(-prod_q) : 18'(prod_q);
	assign q10_full = 38'(pmag) * 38'(RecipTen);
	assign q10 = prod_q[18] ? -19'(q10_full[37:23]) : 19'(q10_full[37:23]);
	assign num10 = 23'(acc_q) * 23'sd10;

	always_comb begin
		dreq.start = state_q == ST_DIV_START;
		dreq.num = num10[22] ? NumW'(-num10) : NumW'(num10);
		dreq.den = div_q[14] ? DenW'(-div_q) : DenW'(div_q);
	end

	cif_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.done(div_done),
		.quo(quo)
	);

	always_comb begin
		if (acc_q[18] ^ div_q[14]) clamped = 8'd0;
		else if (quo > QuoW'(255)) clamped = 8'd255;
		else clamped = quo[7:0];
	end

	assign out_free = !out_valid_q || !out_stall;
	assign last_beat = i_q == nr_q - 2'd1 && j_q == nc_q - 2'd1;

	always_ff @(posedge clk) begin
		if (accept) begin
			top_s1 <= older_mem[col_q];
			mid_s1 <= newer_mem[col_q];
		end
		if (state_q == ST_LOAD) begin
			older_mem[col_q] <= mid_s1;
			newer_mem[col_q] <= px_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlo_q <= 55'd176007801773610;
			whi_q <= 44'd85941309450;
			divider_q <= 11'sd90;
			mode_q <= 1'b0;
			fmt_q <= 2'd1;
			width_q <= 11'd640;
			height_q <= 16'd480;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WEIGHTS_LOW: wlo_q <= cfg_wdata;
				REG_WEIGHTS_HIGH: whi_q <= cfg_wdata[43:0];
				REG_DIVIDER: divider_q <= cfg_wdata[10:0];
				REG_DIV_MODE: mode_q <= cfg_wdata[0];
				REG_FORMAT: fmt_q <= cfg_wdata[1:0];
				REG_WIDTH: width_q <= cfg_wdata[10:0];
				REG_HEIGHT: height_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q <= '0;
			row_q <= '0;
			for (int k = 0; k < 6; k++) wreg_q[k] <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_EMIT) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						px_q <= {alpha_in, chan2_in, chan1_in, chan0_in};
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					win_q[0] <= wreg_q[0];
					win_q[1] <= wreg_q[1];
					win_q[2] <= top_s1;
					win_q[3] <= wreg_q[2];
					win_q[4] <= wreg_q[3];
					win_q[5] <= mid_s1;
					win_q[6] <= wreg_q[4];
					win_q[7] <= wreg_q[5];
					win_q[8] <= px_q;
					wreg_q[0] <= wreg_q[1];
					wreg_q[1] <= top_s1;
					wreg_q[2] <= wreg_q[3];
					wreg_q[3] <= mid_s1;
					wreg_q[4] <= wreg_q[5];
					wreg_q[5] <= px_q;
					alpha_q <= (fmt_q == FMT_RGBA) ? wreg_q[3][31:24] : 8'd0;
					nch_q <= (fmt_q == FMT_GREY) ? 2'd1 : 2'd3;
					for (int k = 0; k < 3; k++) res_q[k] <= 8'd0;
					div_q <= div_sel;
					fend_q <= row_q == h_eff - 16'd1 && {1'b0, col_q} == w_eff - 11'd1;
					if (row_q == 16'd2) begin
						rows_q[0] <= 16'd0;
						rows_q[1] <= row_q - 16'd1;
						rows_q[2] <= h_eff - 16'd1;
						nr_q <= (row_q == h_eff - 16'd1) ? 2'd3 : 2'd2;
					end else begin
						rows_q[0] <= row_q - 16'd1;
						rows_q[1] <= h_eff - 16'd1;
						nr_q <= (row_q == h_eff - 16'd1) ? 2'd2 : 2'd1;
					end
					if (col_q == AddrW'(2)) begin
						cols_q[0] <= 10'd0;
						cols_q[1] <= 10'(col_q - AddrW'(1));
						cols_q[2] <= 10'(w_eff - 11'd1);
						nc_q <= ({1'b0, col_q} == w_eff - 11'd1) ? 2'd3 : 2'd2;
					end else begin
						cols_q[0] <= 10'(col_q - AddrW'(1));
						cols_q[1] <= 10'(w_eff - 11'd1);
						nc_q <= ({1'b0, col_q} == w_eff - 11'd1) ? 2'd2 : 2'd1;
					end
					if (({1'b0, col_q} + 11'd1) >= w_eff) begin
						col_q <= '0;
						row_q <= ((17'(row_q) + 17'd1) >= 17'(h_eff)) ? 16'd0 :
							row_q + 16'd1;
					end else begin
						col_q <= col_q + AddrW'(1);
					end
					ch_q <= 2'd0;
					tap_q <= 4'd0;
					acc_q <= '0;
					state_q <= emit ? ST_MUL : ST_IDLE;
				end
				ST_MUL: begin
					prod_q <= 19'($signed({1'b0, win_q[tap_q][8*ch_q +: 8]})) *
						19'(tap_weight(wall, tap_q));
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					acc_q <= acc_q + q10;
					if (tap_q == 4'd8) begin
						state_q <= ST_DIV_START;
					end else begin
						tap_q <= tap_q + 4'd1;
						state_q <= ST_MUL;
					end
				end
				ST_DIV_START: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done) begin
						res_q[ch_q] <= clamped;
						tap_q <= 4'd0;
						acc_q <= '0;
						if (ch_q + 2'd1 < nch_q) begin
							ch_q <= ch_q + 2'd1;
							state_q <= ST_MUL;
						end else begin
							i_q <= 2'd0;
							j_q <= 2'd0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_col_q <= cols_q[j_q];
						out_row_q <= rows_q[i_q];
						c0_q <= res_q[0];
						c1_q <= res_q[1];
						c2_q <= res_q[2];
						a_q <= alpha_q;
						run_end_q <= last_beat;
						frame_end_q <= last_beat && fend_q;
						if (j_q == nc_q - 2'd1) begin
							j_q <= 2'd0;
							i_q <= i_q + 2'd1;
						end else begin
							j_q <= j_q + 2'd1;
						end
						if (last_beat) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_col = out_col_q;
	assign out_row = out_row_q;
	assign chan0_out = c0_q;
	assign chan1_out = c1_q;
	assign chan2_out = c2_q;
	assign alpha_out = a_q;
	assign run_end = run_end_q;
	assign frame_end = frame_end_q;

	`ASSERT_IMP_NEXT(a_accept_load, clk, arst_n, accept, state_q == ST_LOAD)
	`ASSERT_IMP(a_frame_run, clk, arst_n, out_valid && frame_end, run_end)
	`ASSERT_IMP(a_div_done_wait, clk, arst_n, div_done, state_q == ST_DIV_WAIT)
endmodule

// ===== tb/sv/tb_conv3x3_image_filter_top.sv =====
`timescale 1ns / 1ps
module tb_conv3x3_image_filter_top;
	import cif_pkg::*;

	typedef struct packed {
		logic [9:0] col;
		logic [15:0] row;
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
		logic [7:0] alpha;
		logic run_last;
		logic frame_last;
	} filt_beat_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [54:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic [7:0] chan0_in, chan1_in, chan2_in, alpha_in;
	logic out_valid;
	logic out_stall;
	logic [9:0] out_col;
	logic [15:0] out_row;
	logic [7:0] chan0_out, chan1_out, chan2_out, alpha_out;
	logic run_end, frame_end;

	filt_beat_t filtered_q[$];
	int errors = 0;
	int send_idle = 0;
	int recv_stall = 0;

	logic [54:0] m_wlow;
	logic [43:0] m_whigh;
	logic [10:0] m_div;
	logic m_mode;
	logic [1:0] m_fmt;
	logic [10:0] m_width;
	logic [15:0] m_height;
	logic [31:0] older_mem[MaxWidth];
	logic [31:0] newer_mem[MaxWidth];
	logic [31:0] win_regs[6];
	int col_cnt, row_cnt;

	conv3x3_image_filter_top dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall);
	end

	always @(posedge clk) begin
		filt_beat_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (filtered_q.size() == 0) begin
				$error("output beat with nothing expected: col %0d row %0d", out_col, out_row);
				errors++;
			end else begin
				e = filtered_q.pop_front();
				if (out_col !== e.col) begin
					$error("out_col expected %0d got %0d", e.col, out_col);
					errors++;
				end
				if (out_row !== e.row) begin
					$error("out_row expected %0d got %0d", e.row, out_row);
					errors++;
				end
				if (chan0_out !== e.c0) begin
					$error("chan0_out expected %0d got %0d", e.c0, chan0_out);
					errors++;
				end
				if (chan1_out !== e.c1) begin
					$error("chan1_out expected %0d got %0d", e.c1, chan1_out);
					errors++;
				end
				if (chan2_out !== e.c2) begin
					$error("chan2_out expected %0d got %0d", e.c2, chan2_out);
					errors++;
				end
				if (alpha_out !== e.alpha) begin
					$error("alpha_out expected %0d got %0d", e.alpha, alpha_out);
					errors++;
				end
				if (run_end !== e.run_last) begin
					$error("run_end expected %0d got %0d", e.run_last, run_end);
					errors++;
				end
				if (frame_end !== e.frame_last) begin
					$error("frame_end expected %0d got %0d", e.frame_last, frame_end);
					errors++;
				end
			end
		end
	end

	function automatic logic [7:0] filter_channel(input logic [31:0] win[9], input int wt[9],
		input longint dv, input int ch);
		longint acc;
		longint q;
		longint p;
		acc = 0;
		for (int k = 0; k < 9; k++) begin
			p = longint'((win[k] >> (8 * ch)) & 32'hFF);
			acc += (p * longint'(wt[k])) / 10;
		end
		q = (acc * 10) / dv;
		if (q > 255) return 8'd255;
		if (q < 0) return 8'd0;
		return q[7:0];
	endfunction

	task automatic predict_pixel(input logic [7:0] p0, p1, p2, pa);
		int w, h, c, r, nr, nc;
		logic [31:0] px, top, mid;
		logic [31:0] win[9];
		int wt[9];
		longint dv;
		logic [7:0] res[3];
		logic [7:0] alpha;
		int rows[3];
		int cols[3];
		logic [98:0] wall;
		filt_beat_t b;
		w = m_width;
		h = m_height;
		c = col_cnt;
		r = row_cnt;
		if (w < 3) w = 3;
		if (w > MaxWidth) w = MaxWidth;
		if (h < 3) h = 3;
		if (c >= MaxWidth) c = 0;
		px = {pa, p2, p1, p0};
		top = older_mem[c];
		mid = newer_mem[c];
		win = '{win_regs[0], win_regs[1], top, win_regs[2], win_regs[3], mid,
			win_regs[4], win_regs[5], px};
		if (r >= 2 && r < h && c >= 2 && c < w) begin
			wall = {m_whigh, m_wlow};
			for (int k = 0; k < 9; k++) wt[k] = int'($signed(wall[11*k +: 11]));
			if (m_mode) begin
				dv = 0;
				for (int k = 0; k < 9; k++) dv += wt[k];
			end else begin
				dv = longint'($signed(m_div));
			end
			if (dv == 0) dv = 10;
			res = '{8'd0, 8'd0, 8'd0};
			for (int ch = 0; ch < ((m_fmt == FMT_GREY) ? 1 : 3); ch++)
				res[ch] = filter_channel(win, wt, dv, ch);
			alpha = (m_fmt == FMT_RGBA) ? win[4][31:24] : 8'd0;
			nr = 0;
			nc = 0;
			if (r == 2) rows[nr++] = 0;
			rows[nr++] = r - 1;
			if (r == h - 1) rows[nr++] = h - 1;
			if (c == 2) cols[nc++] = 0;
			cols[nc++] = c - 1;
			if (c == w - 1) cols[nc++] = w - 1;
			for (int i = 0; i < nr; i++) begin
				for (int j = 0; j < nc; j++) begin
					b.col = cols[j][9:0];
					b.row = rows[i][15:0];
					b.c0 = res[0];
					b.c1 = res[1];
					b.c2 = res[2];
					b.alpha = alpha;
					b.run_last = (i == nr - 1) && (j == nc - 1);
					b.frame_last = b.run_last && r == h - 1 && c == w - 1;
					filtered_q.push_back(b);
				end
			end
		end
		older_mem[c] = mid;
		newer_mem[c] = px;
		win_regs[0] = win_regs[1];
		win_regs[1] = top;
		win_regs[2] = win_regs[3];
		win_regs[3] = mid;
		win_regs[4] = win_regs[5];
		win_regs[5] = px;
		if (c + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_cnt = c + 1;
		end
	endtask

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_pixel(input logic [7:0] p0, p1, p2, pa);
		in_valid <= 1'b1;
		chan0_in <= p0;
		chan1_in <= p1;
		chan2_in <= p2;
		alpha_in <= pa;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_pixel(p0, p1, p2, pa);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
	endtask

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++) send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
	endtask

	// Sends pixels until the raster position returns to the top left corner.
	task automatic send_to_frame_end();
		do send_random(1); while (!(col_cnt == 0 && row_cnt == 0));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (filtered_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [54:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WEIGHTS_LOW: m_wlow = v;
			REG_WEIGHTS_HIGH: m_whigh = v[43:0];
			REG_DIVIDER: m_div = v[10:0];
			REG_DIV_MODE: m_mode = v[0];
			REG_FORMAT: m_fmt = v[1:0];
			REG_WIDTH: m_width = v[10:0];
			REG_HEIGHT: m_height = v[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_weights(input logic [98:0] w);
		write_reg(REG_WEIGHTS_LOW, w[54:0]);
		write_reg(REG_WEIGHTS_HIGH, {11'd0, w[98:55]});
	endtask

	function automatic logic [98:0] all_taps(input logic [10:0] t);
		return {9{t}};
	endfunction

	task automatic test_reset_defaults();
		write_reg(REG_WIDTH, 55'd3);
		write_reg(REG_HEIGHT, 55'd3);
		send_pixel(8'd0, 8'd255, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255, 8'd0);
		send_random(7);
		wait_drained();
	endtask

	task automatic test_weight_extremes();
		write_weights(all_taps(11'h3FF));
		write_reg(REG_DIVIDER, 55'd1000);
		write_reg(REG_FORMAT, {53'd0, FMT_RGBA});
		for (int i = 0; i < 9; i++) send_pixel(8'd255, 8'd128, 8'd1, 8'($urandom_range(255)));
		wait_drained();
		write_weights(all_taps(11'h400));
		write_reg(REG_DIV_MODE, 55'd1);
		write_reg(REG_FORMAT, {53'd0, FMT_GREY});
		send_random(9);
		wait_drained();
	endtask

	task automatic test_divisor_cases();
		write_weights({11'd20, 11'h7F6, 11'd10, 11'h7EC, 11'd30, 11'h7F6, 11'h7F6, 11'd0, 11'h7F6});
		send_random(9);
		wait_drained();
		write_reg(REG_DIV_MODE, 55'd0);
		write_reg(REG_DIVIDER, 55'd0);
		write_reg(REG_FORMAT, 55'd3);
		send_random(9);
		wait_drained();
		write_weights(all_taps(11'd7));
		write_reg(REG_DIVIDER, 55'(11'h418));
		send_random(9);
		wait_drained();
		write_reg(REG_DIVIDER, 55'(11'h7FF));
		write_weights(all_taps(11'h7F1));
		send_random(9);
		wait_drained();
	endtask

	task automatic test_size_limits();
		write_weights(all_taps(11'd10));
		write_reg(REG_DIVIDER, 55'd90);
		write_reg(REG_FORMAT, {53'd0, FMT_GREY});
		write_reg(REG_WIDTH, 55'd0);
		write_reg(REG_HEIGHT, 55'd0);
		send_to_frame_end();
		wait_drained();
		write_reg(REG_WIDTH, 55'd2047);
		write_reg(REG_HEIGHT, 55'd2);
		send_random(8);
		wait_drained();
	endtask

	task automatic test_resize_mid_frame();
		write_reg(REG_FORMAT, {53'd0, FMT_RGBA});
		write_reg(REG_WIDTH, 55'd3);
		write_reg(REG_HEIGHT, 55'd65535);
		send_random(9);
		wait_drained();
		write_reg(REG_HEIGHT, 55'd4);
		send_to_frame_end();
		wait_drained();
		write_reg(REG_WIDTH, 55'd10);
		write_reg(REG_HEIGHT, 55'd5);
		send_random(23);
		wait_drained();
		write_reg(REG_WIDTH, 55'd3);
		send_to_frame_end();
		wait_drained();
	endtask

	task automatic test_random_frames();
		logic [98:0] w;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 76; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 76; end
				default: begin send_idle = 25; recv_stall = 25; end
			endcase
			for (int k = 0; k < 9; k++)
				w[11*k +: 11] = ($urandom_range(3) == 0) ? 11'($urandom_range(2047))
					: 11'($signed($urandom_range(60)) - 20);
			write_weights(w);
			write_reg(REG_DIVIDER, 55'(11'($signed($urandom_range(2000)) - 1000)));
			write_reg(REG_DIV_MODE, 55'($urandom_range(1)));
			write_reg(REG_FORMAT, 55'($urandom_range(3)));
			write_reg(REG_WIDTH, 55'($urandom_range(3, 6)));
			write_reg(REG_HEIGHT, 55'($urandom_range(3, 5)));
			send_to_frame_end();
			wait_drained();
		end
	endtask

	initial begin
		m_wlow = 55'd176007801773610;
		m_whigh = 44'd85941309450;
		m_div = 11'd90;
		m_mode = 1'b0;
		m_fmt = 2'd1;
		m_width = 11'd640;
		m_height = 16'd480;
		foreach (older_mem[i]) older_mem[i] = '0;
		foreach (newer_mem[i]) newer_mem[i] = '0;
		foreach (win_regs[i]) win_regs[i] = '0;
		col_cnt = 0;
		row_cnt = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		chan0_in <= '0;
		chan1_in <= '0;
		chan2_in <= '0;
		alpha_in <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_weight_extremes();
		test_divisor_cases();
		test_size_limits();
		test_resize_mid_frame();
		test_random_frames();
		wait_drained();
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cif_pkg.sv
rtl/cif_divider.sv
rtl/conv3x3_image_filter_top.sv
tb/sv/tb_conv3x3_image_filter_top.sv
